@@ rtl/swa_pkg.sv @@
// Shared types and constants for the sliding window assigner.
// Depends on nothing; used by rtl/sliding_window_assigner.sv.
package swa_pkg;

  localparam int unsigned TS_W    = 63;  // timestamp width
  localparam int unsigned CFG_W   = 32;  // size, slide and count width
  localparam int unsigned BOUND_W = 64;  // window start and end bound width
  localparam int unsigned STEP_W  = 7;   // divider step counter width

  // The shared divider first runs 63 steps on the timestamp, then 32 on the size.
  localparam logic [STEP_W-1:0] DIV_TS_LAST = STEP_W'(TS_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(TS_W + CFG_W - 1);

  // Configuration register indexes.
  localparam logic CFG_IDX_SIZE  = 1'b0;
  localparam logic CFG_IDX_SLIDE = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET  = 32'd1000;
  localparam logic [CFG_W-1:0] SLIDE_RESET = 32'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COUNT,
    ST_MUL,
    ST_FIN
  } swa_state_t;

endpackage

@@ rtl/sliding_window_assigner.sv @@
// Sliding window assigner: maps a timestamp to its range of sliding windows.
// Depends on rtl/swa_pkg.sv.
// A shared restoring divider takes 63 steps for timestamp / slide and 32 steps for
// size / slide, then count, multiply and compare.
// in_tready is high only while no word is in work; a finished result waits in the
// output register without blocking the next input word.
// Reset (rst_n, synchronous, active low) sets size and slide to 1000 and clears the
// stored window range and count.
module sliding_window_assigner (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [62:0] timestamp, [63] zero
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // [31:0] window_count, [95:32] first_window_start,
                                   // [159:96] window_end_bound
  output logic         out_tuser,  // [0] refresh
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned TW = swa_pkg::TS_W;
  localparam int unsigned CW = swa_pkg::CFG_W;
  localparam int unsigned BW = swa_pkg::BOUND_W;
  localparam int unsigned SW = swa_pkg::STEP_W;

  swa_pkg::swa_state_t state_r, state_nxt;

  logic [CW-1:0] cfg_size_r, cfg_slide_r;
  logic [CW-1:0] slide_r, slide_nxt;
  logic [TW-1:0] ts_r, ts_nxt;
  logic [TW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [TW-1:0] q1_r, q1_nxt;
  logic [CW-1:0] rem1_r, rem1_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] last_start_r, last_start_nxt;
  logic [BW-1:0] prod_r, prod_nxt;

  logic [BW-1:0] stored_first_r, stored_first_nxt;
  logic [BW-1:0] stored_end_r, stored_end_nxt;
  logic [CW-1:0] stored_count_r, stored_count_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic [BW-1:0] out_first_r, out_first_nxt;
  logic [BW-1:0] out_end_r, out_end_nxt;
  logic          out_refresh_r, out_refresh_nxt;

  logic          in_accept;
  logic          out_free;
  logic          cfg_ready_c;

  // Divider step: one restoring subtract of the slide per cycle.
  logic [CW:0]   part;
  logic [CW:0]   diff;
  logic          q_bit;
  logic [CW-1:0] rem_step;
  logic [TW-1:0] dvd_step;

  // Count and final range terms.
  logic [CW:0]   by_size;
  logic [BW-1:0] by_zero;
  logic [BW-1:0] first_c;
  logic [BW-1:0] end_c;
  logic          refresh_c;

  assign part     = {rem_r, dvd_r[TW-1]};
  assign diff     = part - {1'b0, slide_r};
  assign q_bit    = (part >= {1'b0, slide_r});
  assign rem_step = q_bit ? diff[CW-1:0] : part[CW-1:0];
  assign dvd_step = {dvd_r[TW-2:0], q_bit};

  // size - rem - 1 over slide equals size / slide, less one when size % slide <= rem.
  assign by_size = {1'b0, dvd_r[CW-1:0]} + {{CW{1'b0}}, (rem_r > rem1_r)};
  assign by_zero = {1'b0, q1_r} + 64'd1;

  assign first_c   = (cnt_r == '0) ? last_start_r + {{(BW-CW){1'b0}}, slide_r}
                                   : last_start_r - prod_r;
  assign end_c     = last_start_r + {{(BW-CW){1'b0}}, cfg_size_r};
  assign refresh_c = (first_c != stored_first_r) || (end_c != stored_end_r);

  assign out_free  = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swa_pkg::ST_IDLE:  if (in_tvalid) state_nxt = swa_pkg::ST_DIV;
      swa_pkg::ST_DIV:   if (step_r == swa_pkg::DIV_LAST) state_nxt = swa_pkg::ST_COUNT;
      swa_pkg::ST_COUNT: state_nxt = swa_pkg::ST_MUL;
      swa_pkg::ST_MUL:   state_nxt = swa_pkg::ST_FIN;
      swa_pkg::ST_FIN:   if (out_free) state_nxt = swa_pkg::ST_IDLE;
      default:           state_nxt = swa_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready   = (state_r == swa_pkg::ST_IDLE);
    cfg_ready_c = 1'b1;
  end

  assign cfg_ready  = cfg_ready_c;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_end_r, out_first_r, out_count_r};
  assign out_tuser  = out_refresh_r;

  // Datapath next values.
  always_comb begin
    slide_nxt        = slide_r;
    ts_nxt           = ts_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    step_nxt         = step_r;
    q1_nxt           = q1_r;
    rem1_nxt         = rem1_r;
    cnt_nxt          = cnt_r;
    last_start_nxt   = last_start_r;
    prod_nxt         = prod_r;
    stored_first_nxt = stored_first_r;
    stored_end_nxt   = stored_end_r;
    stored_count_nxt = stored_count_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_count_nxt    = out_count_r;
    out_first_nxt    = out_first_r;
    out_end_nxt      = out_end_r;
    out_refresh_nxt  = out_refresh_r;

    unique case (state_r)
      swa_pkg::ST_IDLE: begin
        if (in_accept) begin
          // A zero slide behaves as a slide of one.
          slide_nxt = (cfg_slide_r == '0) ? CW'(1) : cfg_slide_r;
          ts_nxt    = in_tdata[TW-1:0];
          dvd_nxt   = in_tdata[TW-1:0];
          rem_nxt   = '0;
          step_nxt  = '0;
        end
      end
      swa_pkg::ST_DIV: begin
        step_nxt = step_r + SW'(1);
        if (step_r == swa_pkg::DIV_TS_LAST) begin
          // Timestamp division done; restart the unit on the size.
          q1_nxt   = dvd_step;
          rem1_nxt = rem_step;
          rem_nxt  = '0;
          dvd_nxt  = {cfg_size_r, {(TW-CW){1'b0}}};
        end else begin
          rem_nxt = rem_step;
          dvd_nxt = dvd_step;
        end
      end
      swa_pkg::ST_COUNT: begin
        if (cfg_size_r <= rem1_r) begin
          cnt_nxt = '0;
        end else if (by_zero < {{(BW-CW-1){1'b0}}, by_size}) begin
          cnt_nxt = by_zero[CW-1:0];
        end else begin
          cnt_nxt = by_size[CW-1:0];
        end
        last_start_nxt = {1'b0, ts_r} - {{(BW-CW){1'b0}}, rem1_r};
      end
      swa_pkg::ST_MUL: begin
        prod_nxt = {{(BW-CW){1'b0}}, cnt_r - CW'(1)} * {{(BW-CW){1'b0}}, slide_r};
      end
      swa_pkg::ST_FIN: begin
        if (out_free) begin
          if (refresh_c) begin
            stored_first_nxt = first_c;
            stored_end_nxt   = end_c;
            stored_count_nxt = cnt_r;
          end
          out_valid_nxt   = 1'b1;
          out_refresh_nxt = refresh_c;
          out_count_nxt   = refresh_c ? cnt_r   : stored_count_r;
          out_first_nxt   = refresh_c ? first_c : stored_first_r;
          out_end_nxt     = refresh_c ? end_c   : stored_end_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= swa_pkg::ST_IDLE;
      cfg_size_r     <= swa_pkg::SIZE_RESET;
      cfg_slide_r    <= swa_pkg::SLIDE_RESET;
      stored_first_r <= '0;
      stored_end_r   <= '0;
      stored_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      stored_first_r <= stored_first_nxt;
      stored_end_r   <= stored_end_nxt;
      stored_count_r <= stored_count_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready_c) begin
        unique case (cfg_index)
          swa_pkg::CFG_IDX_SIZE:  cfg_size_r  <= cfg_data;
          swa_pkg::CFG_IDX_SLIDE: cfg_slide_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    slide_r       <= slide_nxt;
    ts_r          <= ts_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    step_r        <= step_nxt;
    q1_r          <= q1_nxt;
    rem1_r        <= rem1_nxt;
    cnt_r         <= cnt_nxt;
    last_start_r  <= last_start_nxt;
    prod_r        <= prod_nxt;
    out_count_r   <= out_count_nxt;
    out_first_r   <= out_first_nxt;
    out_end_r     <= out_end_nxt;
    out_refresh_r <= out_refresh_nxt;
  end

`ifndef SYNTHESIS
  // The partial remainder always stays below the divisor.
  a_rem_below_slide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swa_pkg::ST_DIV) |-> (rem_r < slide_r))
    else $error("divider remainder reached the slide");

  // The divider hands over only after its full step count.
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swa_pkg::ST_DIV && state_nxt == swa_pkg::ST_COUNT)
      |-> (step_r == swa_pkg::DIV_LAST))
    else $error("divider left early");

  // The stored count only changes together with a refresh result.
  a_count_with_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && stored_count_r != $past(stored_count_r))
      |-> (out_valid_r && out_refresh_r))
    else $error("stored count changed without refresh");

  // A refresh result carries exactly the stored range.
  a_refresh_matches_store: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r) == swa_pkg::ST_FIN && out_valid_r && out_refresh_r)
      |-> (out_first_r == stored_first_r && out_end_r == stored_end_r))
    else $error("refresh word differs from stored range");
`endif

endmodule
